// File: rtl/core/skt_pkg.sv
package skt_pkg;

    localparam int FUNC_W = 3;
    localparam int KEY_W  = 27;
    localparam int PAY_W  = 32;
    localparam int IDX_W  = 7;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 7;

    localparam int DEF_MAX_ENTRIES  = 64;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WR_IDX = 3'd3;
    localparam logic [FUNC_W-1:0] FN_RD_IDX = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  entry_key;
        logic [PAY_W-1:0]  entry_payload;
        logic [IDX_W-1:0]  entry_index;
    } t_cmd;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              hit;
        logic [KEY_W-1:0]  key_out;
        logic [PAY_W-1:0]  payload_out;
        logic [CNT_W-1:0]  count_out;
    } t_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT,
        S_PUT,
        S_IDX_RD
    } t_state;

endpackage

// File: rtl/core/skt_ram.sv
module skt_ram #(
    parameter int DEPTH = skt_pkg::DEF_MAX_ENTRIES,
    parameter int WIDTH = skt_pkg::KEY_W + skt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sorted_key_table_top.sv
// Sorted key table: up to MAX_ENTRIES key/payload entries kept in ascending key
// order in one single-port-read, single-port-write RAM. A command beat is taken
// when start is high and busy is low; its one result shows on o_rsp for a single
// cycle with o_valid high and cannot be stalled. busy drops in that same cycle,
// so the next command can be issued right away. Each binary-search probe reads
// the RAM in S_SRCH_RD and then compares in S_SRCH_CMP; a search by key makes
// at most log2(count)+1 probes. Insert into a non-empty table then moves each
// entry with a larger key up one slot, with one RAM read per cycle of the shift
// loop, and writes the new entry into the slot left free. Indexed write is done
// in S_DECODE; indexed read reads the RAM there and returns from S_IDX_RD.
// Table contents are undefined until written; only the count, state and result
// strobe reset.
module sorted_key_table_top #(
    parameter int MAX_ENTRIES  = skt_pkg::DEF_MAX_ENTRIES,
    parameter int PAYLOAD_BITS = skt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  skt_pkg::t_cmd i_cmd,
    output logic          o_valid,
    output skt_pkg::t_rsp o_rsp
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = skt_pkg::IDX_W;
    localparam int CMPW = (CW > IW) ? CW : IW;
    localparam int KW   = skt_pkg::KEY_W;
    localparam int OPW  = skt_pkg::PAY_W;
    localparam int OCW  = skt_pkg::CNT_W;
    localparam int EW   = KW + PAYLOAD_BITS;

    skt_pkg::t_state r_state, n_state;
    skt_pkg::t_cmd   r_cmd;
    skt_pkg::t_rsp   r_rsp, n_rsp;
    logic            r_valid, n_valid;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_lo, n_lo;
    logic [CW-1:0]   r_hp, n_hp;       // search window is [lo, hp)
    logic [AW-1:0]   r_mid, n_mid;
    logic [AW-1:0]   r_ins, n_ins;     // free slot that the insert shift fills next

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;

    logic [CW:0]           w_mid_sum;
    logic [AW-1:0]         w_mid;
    logic                  w_srch_go;
    logic [KW-1:0]         w_rd_key;
    logic [PAYLOAD_BITS-1:0] w_rd_pay;
    logic [PAYLOAD_BITS-1:0] w_new_pay;
    logic                  w_key_lt, w_key_gt, w_hit;
    logic                  w_full, w_idx_ok, w_last_shift;
    logic [AW-1:0]         w_idx_addr;
    logic [CMPW-1:0]       w_idx_ext;

    skt_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy    = (r_state != skt_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    assign w_mid_sum = (CW+1)'(r_lo) + (CW+1)'(r_hp) - (CW+1)'(1);
    assign w_mid     = AW'(w_mid_sum >> 1);
    assign w_srch_go = (r_lo < r_hp);

    assign w_rd_key  = ram_rdata[EW-1 -: KW];
    assign w_rd_pay  = ram_rdata[PAYLOAD_BITS-1:0];
    assign w_new_pay = PAYLOAD_BITS'(r_cmd.entry_payload);

    assign w_key_lt  = (r_cmd.entry_key < w_rd_key);
    assign w_key_gt  = (r_cmd.entry_key > w_rd_key);
    assign w_hit     = !w_key_lt && !w_key_gt;

    assign w_full       = (r_count >= CW'(MAX_ENTRIES));
    assign w_idx_ext    = CMPW'(r_cmd.entry_index);
    assign w_idx_ok     = (r_cmd.entry_index != '0) && (w_idx_ext <= CMPW'(r_count));
    assign w_idx_addr   = AW'(w_idx_ext - CMPW'(1));
    assign w_last_shift = (r_ins == AW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
                if (start) begin
                    n_state = skt_pkg::S_DECODE;
                end
            end
            skt_pkg::S_DECODE: begin
                unique case (r_cmd.func)
                    skt_pkg::FN_INSERT: begin
                        n_state = w_full ? skt_pkg::S_IDLE : skt_pkg::S_SRCH_RD;
                    end
                    skt_pkg::FN_UPDATE,
                    skt_pkg::FN_LOOKUP: n_state = skt_pkg::S_SRCH_RD;
                    skt_pkg::FN_RD_IDX: begin
                        n_state = w_idx_ok ? skt_pkg::S_IDX_RD : skt_pkg::S_IDLE;
                    end
                    default:            n_state = skt_pkg::S_IDLE;
                endcase
            end
            skt_pkg::S_SRCH_RD: begin
                if (w_srch_go) begin
                    n_state = skt_pkg::S_SRCH_CMP;
                end else if (r_cmd.func == skt_pkg::FN_INSERT && r_count != '0) begin
                    n_state = skt_pkg::S_SHIFT;
                end else begin
                    n_state = skt_pkg::S_IDLE;
                end
            end
            skt_pkg::S_SRCH_CMP: begin
                n_state = w_hit ? skt_pkg::S_IDLE : skt_pkg::S_SRCH_RD;
            end
            skt_pkg::S_SHIFT: begin
                if (!w_key_lt) begin
                    n_state = skt_pkg::S_IDLE;
                end else if (w_last_shift) begin
                    n_state = skt_pkg::S_PUT;
                end
            end
            skt_pkg::S_PUT:    n_state = skt_pkg::S_IDLE;
            skt_pkg::S_IDX_RD: n_state = skt_pkg::S_IDLE;
            default:           n_state = skt_pkg::S_IDLE;
        endcase
    end

    // datapath, RAM control and result
    always_comb begin
        n_lo      = r_lo;
        n_hp      = r_hp;
        n_mid     = r_mid;
        n_ins     = r_ins;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_rsp     = '0;
        ram_we    = 1'b0;
        ram_waddr = r_ins;
        ram_wdata = {r_cmd.entry_key, w_new_pay};
        ram_re    = 1'b0;
        ram_raddr = w_mid;
        unique case (r_state)
            skt_pkg::S_IDLE: begin
            end
            skt_pkg::S_DECODE: begin
                n_lo = '0;
                n_hp = r_count;
                unique case (r_cmd.func)
                    skt_pkg::FN_INSERT: begin
                        if (w_full) begin
                            n_valid      = 1'b1;
                            n_rsp.status = skt_pkg::ST_FULL;
                        end
                    end
                    skt_pkg::FN_UPDATE,
                    skt_pkg::FN_LOOKUP: begin
                    end
                    skt_pkg::FN_WR_IDX: begin
                        n_valid = 1'b1;
                        if (w_idx_ok) begin
                            ram_we       = 1'b1;
                            ram_waddr    = w_idx_addr;
                            n_rsp.status = skt_pkg::ST_OK;
                        end else begin
                            n_rsp.status = skt_pkg::ST_BAD_INDEX;
                        end
                    end
                    skt_pkg::FN_RD_IDX: begin
                        if (w_idx_ok) begin
                            ram_re    = 1'b1;
                            ram_raddr = w_idx_addr;
                        end else begin
                            n_valid      = 1'b1;
                            n_rsp.status = skt_pkg::ST_BAD_INDEX;
                        end
                    end
                    default: begin
                        n_valid      = 1'b1;
                        n_rsp.status = skt_pkg::ST_OK;
                    end
                endcase
            end
            skt_pkg::S_SRCH_RD: begin
                if (w_srch_go) begin
                    ram_re = 1'b1;
                    n_mid  = w_mid;
                end else if (r_cmd.func == skt_pkg::FN_INSERT) begin
                    n_ins = AW'(r_count);
                    if (r_count == '0) begin
                        // empty table: place at slot 0 directly
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        n_count   = r_count + CW'(1);
                        n_valid   = 1'b1;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(r_count - CW'(1));
                    end
                end else begin
                    n_valid      = 1'b1;
                    n_rsp.status = skt_pkg::ST_NOT_FOUND;
                end
            end
            skt_pkg::S_SRCH_CMP: begin
                if (w_hit) begin
                    n_valid       = 1'b1;
                    n_rsp.hit     = 1'b1;
                    n_rsp.key_out = w_rd_key;
                    if (r_cmd.func == skt_pkg::FN_INSERT) begin
                        n_rsp.status      = skt_pkg::ST_DUPLICATE;
                        n_rsp.payload_out = OPW'(w_rd_pay);
                    end else if (r_cmd.func == skt_pkg::FN_UPDATE) begin
                        ram_we            = 1'b1;
                        ram_waddr         = r_mid;
                        ram_wdata         = {w_rd_key, w_new_pay};
                        n_rsp.payload_out = OPW'(w_new_pay);
                    end else begin
                        n_rsp.payload_out = OPW'(w_rd_pay);
                    end
                end else if (w_key_lt) begin
                    n_hp = CW'(r_mid);
                end else begin
                    n_lo = CW'(r_mid) + CW'(1);
                end
            end
            skt_pkg::S_SHIFT: begin
                // read data holds slot r_ins-1; move it up while its key is larger
                if (w_key_lt) begin
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata;
                    n_ins     = r_ins - AW'(1);
                    if (!w_last_shift) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_ins - AW'(2);
                    end
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                    n_valid = 1'b1;
                end
            end
            skt_pkg::S_PUT: begin
                ram_we  = 1'b1;
                n_count = r_count + CW'(1);
                n_valid = 1'b1;
            end
            skt_pkg::S_IDX_RD: begin
                n_valid           = 1'b1;
                n_rsp.key_out     = w_rd_key;
                n_rsp.payload_out = OPW'(w_rd_pay);
            end
            default: begin
            end
        endcase
        n_rsp.count_out = OCW'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skt_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_lo  <= n_lo;
        r_hp  <= n_hp;
        r_mid <= n_mid;
        r_ins <= n_ins;
        r_rsp <= n_rsp;
    end

`ifndef SYNTH
    a_no_rw_collide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same entry");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == skt_pkg::S_IDLE))
        else $error("result strobe while still busy");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == skt_pkg::S_DECODE))
        else $error("accepted command beat not decoded");
`endif

endmodule

// File: tb/tb.sv
module tb;

    localparam int KW = skt_pkg::KEY_W;
    localparam int PW = skt_pkg::PAY_W;
    localparam int IW = skt_pkg::IDX_W;
    localparam int FW = skt_pkg::FUNC_W;
    localparam int CW = skt_pkg::CNT_W;

    localparam int TBL_DEPTH      = skt_pkg::DEF_MAX_ENTRIES;
    localparam int ITEMS_PER_PASS = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 80;
    localparam int MAX_REPORTS    = 10;

    localparam logic [KW-1:0] KEY_MAX = 27'd99999999;
    localparam logic [PW-1:0] PAY_MAX = 32'hFFFF_FFFF;
    localparam logic [IW-1:0] IDX_MAX = 7'd64;

    // func codes the block leaves unused
    localparam logic [FW-1:0] FN_RSVD5 = 3'd5;
    localparam logic [FW-1:0] FN_RSVD6 = 3'd6;
    localparam logic [FW-1:0] FN_RSVD7 = 3'd7;

    class key_table_shadow;
        logic [KW-1:0]   keys [TBL_DEPTH];
        logic [PW-1:0]   pays [TBL_DEPTH];
        int              fill = 0;
        skt_pkg::t_rsp   expected_rsp [$];
        int              errors = 0;

        // same probe order as the hardware: positions 0..fill-1
        function int find_pos(logic [KW-1:0] k);
            int lo;
            int hi;
            int mid;
            lo = 0;
            hi = fill - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (k < keys[mid]) hi = mid - 1;
                else if (k > keys[mid]) lo = mid + 1;
                else return mid;
            end
            return -1;
        endfunction

        function void note_command(skt_pkg::t_cmd c);
            skt_pkg::t_rsp r;
            int            pos;
            int            i;
            r = '0;
            case (c.func)
                skt_pkg::FN_INSERT: begin
                    if (fill >= TBL_DEPTH) begin
                        r.status = skt_pkg::ST_FULL;
                    end else begin
                        pos = find_pos(c.entry_key);
                        if (pos >= 0) begin
                            r.status      = skt_pkg::ST_DUPLICATE;
                            r.hit         = 1'b1;
                            r.key_out     = keys[pos];
                            r.payload_out = pays[pos];
                        end else begin
                            i = fill;
                            while (i >= 1 && keys[i-1] > c.entry_key) begin
                                keys[i] = keys[i-1];
                                pays[i] = pays[i-1];
                                i--;
                            end
                            keys[i] = c.entry_key;
                            pays[i] = c.entry_payload;
                            fill++;
                        end
                    end
                end
                skt_pkg::FN_UPDATE, skt_pkg::FN_LOOKUP: begin
                    pos = find_pos(c.entry_key);
                    if (pos < 0) begin
                        r.status = skt_pkg::ST_NOT_FOUND;
                    end else begin
                        if (c.func == skt_pkg::FN_UPDATE) pays[pos] = c.entry_payload;
                        r.hit         = 1'b1;
                        r.key_out     = keys[pos];
                        r.payload_out = pays[pos];
                    end
                end
                skt_pkg::FN_WR_IDX, skt_pkg::FN_RD_IDX: begin
                    if (c.entry_index < 1 || c.entry_index > fill) begin
                        r.status = skt_pkg::ST_BAD_INDEX;
                    end else if (c.func == skt_pkg::FN_WR_IDX) begin
                        keys[c.entry_index - 1] = c.entry_key;
                        pays[c.entry_index - 1] = c.entry_payload;
                    end else begin
                        r.key_out     = keys[c.entry_index - 1];
                        r.payload_out = pays[c.entry_index - 1];
                    end
                end
                default: ;
            endcase
            r.count_out = CW'(fill);
            expected_rsp.push_back(r);
        endfunction

        function void check_response(skt_pkg::t_rsp got);
            skt_pkg::t_rsp e;
            if (expected_rsp.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result beat st=%0d hit=%0b key=%0d pay=%h cnt=%0d",
                             $time, got.status, got.hit, got.key_out, got.payload_out,
                             got.count_out);
                return;
            end
            e = expected_rsp.pop_front();
            if (got.status !== e.status || got.hit !== e.hit || got.key_out !== e.key_out ||
                got.payload_out !== e.payload_out || got.count_out !== e.count_out) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("%0t: mismatch exp st=%0d hit=%0b key=%0d pay=%h cnt=%0d",
                             $time, e.status, e.hit, e.key_out, e.payload_out, e.count_out);
                    $display("%0t:          got st=%0d hit=%0b key=%0d pay=%h cnt=%0d",
                             $time, got.status, got.hit, got.key_out, got.payload_out,
                             got.count_out);
                end
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    skt_pkg::t_cmd cmd_beat;
    logic          o_valid;
    skt_pkg::t_rsp rsp_beat;

    key_table_shadow sb = new;
    int idle_cycles;

    sorted_key_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (cmd_beat),
        .o_valid (o_valid),
        .o_rsp   (rsp_beat)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) sb.check_response(rsp_beat);
    end

    // ends the run if neither side moves a beat for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_rst_n && start && busy === 1'b0) || o_valid === 1'b1) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic skt_pkg::t_cmd cmd_of(logic [FW-1:0] f, logic [KW-1:0] k,
                                             logic [PW-1:0] p, logic [IW-1:0] x);
        skt_pkg::t_cmd c;
        c.func          = f;
        c.entry_key     = k;
        c.entry_payload = p;
        c.entry_index   = x;
        return c;
    endfunction

    // mixed traffic: keys often already held, indexes mostly in range
    function automatic skt_pkg::t_cmd random_cmd();
        skt_pkg::t_cmd c;
        int            r;
        int            j;
        logic [KW-1:0] k;
        r = $urandom_range(0, 9);
        if (r <= 3 && sb.fill > 0) begin
            k = sb.keys[$urandom_range(0, sb.fill - 1)];
        end else if (r == 4 && sb.fill > 0) begin
            k = sb.keys[$urandom_range(0, sb.fill - 1)];
            if ($urandom_range(0, 1) && k < KEY_MAX) k = k + KW'(1);
            else if (k > 0) k = k - KW'(1);
        end else if (r == 5) begin
            k = $urandom_range(0, 1) ? KEY_MAX : '0;
        end else begin
            k = KW'($urandom_range(0, int'(KEY_MAX)));
        end
        c.entry_key = k;

        r = $urandom_range(0, 9);
        c.entry_payload = (r == 0) ? '0 : (r == 1) ? PAY_MAX : $urandom();

        r = $urandom_range(0, 9);
        if (r == 0) c.entry_index = '0;
        else if (r == 1) c.entry_index = (sb.fill < TBL_DEPTH) ? IW'(sb.fill + 1) : IDX_MAX;
        else if (r == 2 || sb.fill == 0) c.entry_index = IW'($urandom_range(0, 64));
        else c.entry_index = IW'($urandom_range(1, sb.fill));

        r = $urandom_range(0, 99);
        if (r < 22) begin
            c.func = skt_pkg::FN_INSERT;
        end else if (r < 37) begin
            c.func = skt_pkg::FN_UPDATE;
        end else if (r < 57) begin
            c.func = skt_pkg::FN_LOOKUP;
        end else if (r < 70) begin
            c.func = skt_pkg::FN_WR_IDX;
            j = int'(c.entry_index);
            // rewrite the held key most of the time so order survives
            if ($urandom_range(0, 19) != 0 && j >= 1 && j <= sb.fill)
                c.entry_key = sb.keys[j - 1];
        end else if (r < 95) begin
            c.func = skt_pkg::FN_RD_IDX;
        end else begin
            r = $urandom_range(0, 2);
            c.func = (r == 0) ? FN_RSVD5 : (r == 1) ? FN_RSVD6 : FN_RSVD7;
        end
        return c;
    endfunction

    // called and returns at a falling edge; start left high for the caller
    task automatic issue(input skt_pkg::t_cmd c);
        start    = 1'b1;
        cmd_beat = c;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(c);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start = 1'b0;
        do @(negedge i_clk); while (sb.expected_rsp.size() != 0);
    endtask

    initial begin
        int idle_pct;
        int gap;
        start    = 1'b0;
        cmd_beat = '0;
        i_rst_n  = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, boundary keys, shifts, duplicates, bad indexes
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, 7'd1));
        issue(cmd_of(skt_pkg::FN_LOOKUP, 27'd5, '0, '0));
        issue(cmd_of(skt_pkg::FN_UPDATE, 27'd5, 32'h1, '0));
        issue(cmd_of(skt_pkg::FN_WR_IDX, 27'd9, 32'h2, '0));
        issue(cmd_of(skt_pkg::FN_INSERT, '0, '0, '0));
        issue(cmd_of(skt_pkg::FN_INSERT, KEY_MAX, PAY_MAX, IDX_MAX));
        issue(cmd_of(skt_pkg::FN_INSERT, 27'd50000000, 32'hA5A5_A5A5, '0));
        issue(cmd_of(skt_pkg::FN_INSERT, '0, 32'h1234, '0));
        issue(cmd_of(skt_pkg::FN_INSERT, 27'd1, 32'h5A5A_5A5A, '0));
        issue(cmd_of(skt_pkg::FN_LOOKUP, KEY_MAX, '0, '0));
        issue(cmd_of(skt_pkg::FN_UPDATE, KEY_MAX, '0, '0));
        issue(cmd_of(skt_pkg::FN_UPDATE, 27'd2, PAY_MAX, '0));
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, '0));
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, 7'd1));
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, 7'd4));
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, 7'd5));
        issue(cmd_of(skt_pkg::FN_RD_IDX, '0, '0, IDX_MAX));
        // break the order, search and insert over it, then put it back
        issue(cmd_of(skt_pkg::FN_WR_IDX, 27'd7, 32'hDEAD_BEEF, 7'd4));
        issue(cmd_of(skt_pkg::FN_LOOKUP, 27'd7, '0, '0));
        issue(cmd_of(skt_pkg::FN_INSERT, 27'd3, 32'h0F0F_0F0F, '0));
        issue(cmd_of(skt_pkg::FN_WR_IDX, KEY_MAX, PAY_MAX, 7'd5));
        issue(cmd_of(FN_RSVD5, KEY_MAX, PAY_MAX, IDX_MAX));
        issue(cmd_of(FN_RSVD6, '0, '0, '0));
        issue(cmd_of(FN_RSVD7, KEY_MAX, PAY_MAX, 7'd1));
        issue(cmd_of(skt_pkg::FN_WR_IDX, '0, '0, 7'd1));
        drain();

        for (int pass = 0; pass < 3; pass++) begin
            idle_pct = (pass == 0) ? 28 : (pass == 1) ? 56 : 0;
            for (int n = 0; n < ITEMS_PER_PASS; n++) begin
                issue(random_cmd());
                if ($urandom_range(0, 99) < idle_pct) begin
                    gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 90)
                                                      : $urandom_range(1, 3);
                    start = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
